@@ hw/rtl/ctes_pkg.sv @@
// ----------------------------------------------------------------------------
// ctes_pkg: shared types and constants for the civil time to epoch converter
// Holds field widths, calendar constants and the month offset table.
// ----------------------------------------------------------------------------
package ctes_pkg;

  localparam int YearW  = 8;
  localparam int MonW   = 4;
  localparam int MdayW  = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int OutW   = 33;

  // Day count including the day of the month: at most 67966.
  localparam int DayW   = 17;
  // Seconds within the day from hour, minute and second: at most 115443.
  localparam int TodW   = 17;
  // Days before the month start, leap day included: at most 366.
  localparam int MdayOffW = 9;

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int DaysPerYear = 365;

  // Years since 1900 of the epoch year and of the non-leap century year
  // after the epoch inside the input range (2100).
  localparam int EpochYearOff   = 70;
  localparam int CenturyYearOff = 200;
  // Year base minus one, and the count of multiples of four up to 1971.
  localparam int YearBaseM1   = 1899;
  localparam int Mult4ToEpoch = 492;
  localparam int FebIndex     = 1;
  localparam int MaxDays      = 67966;

  typedef struct packed {
    logic [DayW-1:0] days;
    logic [TodW-1:0] tod_secs;
  } day_item_t;

  // Days in the whole months before the given month of a common year.
  // Month codes above eleven count the full year.
  function automatic logic [MdayOffW-1:0] month_offset(input logic [MonW-1:0] mon);
    logic [MdayOffW-1:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/civil_time_to_epoch_seconds_unit.sv @@
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds_unit: UTC civil time to seconds since 1970
// Four-stage pipeline that converts a broken-down UTC time into epoch seconds.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock cycle while the output is not
// stalled and returns the results in order. The pipeline depth is set by the
// one wide step in the path, the multiply of the day count by 86400, which
// has a stage of its own; the day count and the time-of-day sum take the two
// stages before it and the final correction and clamp the stage after. A
// stall on the output backs up through the stages only as far as there are
// full registers, so bubbles are squeezed out and an input transaction is
// taken whenever some stage has room. Years before 1970 add no whole-year
// days, though the year still decides whether February is long. Month codes
// above eleven count the whole year. A day of month of zero counts as the
// last day of the previous month; where the total falls below one day the
// result clamps at zero. Out-of-range hour, minute and second values are
// used as given. No state is kept apart from the pipeline registers.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ctes_pkg::YearW-1:0]  years_since_1900,
  input  logic [ctes_pkg::MonW-1:0]   month_index,
  input  logic [ctes_pkg::MdayW-1:0]  day_of_month,
  input  logic [ctes_pkg::HourW-1:0]  hour_of_day,
  input  logic [ctes_pkg::MinW-1:0]   minute_of_hour,
  input  logic [ctes_pkg::SecW-1:0]   second_of_minute,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ctes_pkg::OutW-1:0]   epoch_seconds
);

  logic                 in_ready;
  logic                 day_valid;
  logic                 day_ready;
  ctes_pkg::day_item_t  day_item;

  // The input side stalls whenever the first stage cannot take a transaction.
  assign in_stall = !in_ready;

  // Stages A and B: whole-year days, month offset, day of month, time of day.
  ctes_days u_days (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .dn_valid         (day_valid),
    .dn_ready         (day_ready),
    .dn_item          (day_item)
  );

  // Stages C and D: scale to seconds, then drop the day-of-month offset and
  // clamp at zero into the output register.
  ctes_secs u_secs (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (day_valid),
    .up_ready      (day_ready),
    .up_item       (day_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds)
  );

endmodule

@@ hw/rtl/ctes_days.sv @@
// ----------------------------------------------------------------------------
// ctes_days: day count and time-of-day stages
// Two pipeline stages that turn the civil date into a day count (day of month
// included) and the clock time into seconds within the day.
// ----------------------------------------------------------------------------
module ctes_days (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ctes_pkg::YearW-1:0]    years_since_1900,
  input  logic [ctes_pkg::MonW-1:0]     month_index,
  input  logic [ctes_pkg::MdayW-1:0]    day_of_month,
  input  logic [ctes_pkg::HourW-1:0]    hour_of_day,
  input  logic [ctes_pkg::MinW-1:0]     minute_of_hour,
  input  logic [ctes_pkg::SecW-1:0]     second_of_minute,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output ctes_pkg::day_item_t           dn_item
);

  // Stage A registers.
  logic                            a_valid;
  logic [ctes_pkg::DayW-1:0]       a_yr_days;
  logic [ctes_pkg::MonW-1:0]       a_mon;
  logic                            a_leap;
  logic [ctes_pkg::MdayW-1:0]      a_mday;
  logic [ctes_pkg::TodW-1:0]       a_tod;

  // Stage B registers.
  logic                            b_valid;
  ctes_pkg::day_item_t             b_item;

  logic                            a_adv;
  logic                            b_adv;

  // Stage A logic.
  logic [10:0]                     yr_base;
  logic [8:0]                      leaps_all;
  logic [ctes_pkg::YearW-1:0]      yr_span;
  logic [5:0]                      leaps;
  logic                            past_epoch;
  logic                            leap_now;
  logic [ctes_pkg::DayW-1:0]       yr_days_next;
  logic [ctes_pkg::TodW-1:0]       tod_next;

  // Stage B logic.
  logic [ctes_pkg::MdayOffW-1:0]   mon_days;
  logic [ctes_pkg::DayW-1:0]       days_next;

  assign b_adv    = !b_valid || dn_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  always_comb begin
    past_epoch = years_since_1900 >= 8'(ctes_pkg::EpochYearOff);
    yr_base    = 11'(years_since_1900) + 11'(ctes_pkg::YearBaseM1);
    // Leap years from 1970 up to the year before: multiples of four, less
    // 2100 once the year is past it.
    leaps_all  = yr_base[10:2] - 9'(ctes_pkg::Mult4ToEpoch)
                 - 9'(years_since_1900 > 8'(ctes_pkg::CenturyYearOff));
    leaps      = past_epoch ? leaps_all[5:0] : 6'd0;
    yr_span    = past_epoch ? (years_since_1900 - 8'(ctes_pkg::EpochYearOff)) : '0;
    yr_days_next = 17'(yr_span) * 17'(ctes_pkg::DaysPerYear) + 17'(leaps);
    // Within 1900..2155 only 1900 and 2100 are divisible by four yet common.
    leap_now   = (years_since_1900[1:0] == 2'd0) && (years_since_1900 != 8'd0)
                 && (years_since_1900 != 8'(ctes_pkg::CenturyYearOff));
    tod_next   = 17'(hour_of_day) * 17'(ctes_pkg::SecsPerHour)
               + 17'(minute_of_hour) * 17'(ctes_pkg::SecsPerMin)
               + 17'(second_of_minute);
  end

  always_comb begin
    mon_days  = ctes_pkg::month_offset(a_mon);
    days_next = a_yr_days + 17'(mon_days) + 17'(a_mday)
              + 17'(a_leap && (a_mon > 4'(ctes_pkg::FebIndex)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= in_valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
    end
    if (a_adv && in_valid) begin
      a_yr_days <= yr_days_next;
      a_mon     <= month_index;
      a_leap    <= leap_now;
      a_mday    <= day_of_month;
      a_tod     <= tod_next;
    end
    if (b_adv && a_valid) begin
      b_item.days     <= days_next;
      b_item.tod_secs <= a_tod;
    end
  end

  assign dn_valid = b_valid;
  assign dn_item  = b_item;

  a_reset_clear: assert property (@(posedge clk) rst |=> !a_valid && !b_valid)
    else $error("day stages hold a transaction after reset");

  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> a_valid)
    else $error("accepted transaction missing from stage A");

  a_days_range: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_item.days <= 17'(ctes_pkg::MaxDays)))
    else $error("day count out of range");

endmodule

@@ hw/rtl/ctes_secs.sv @@
// ----------------------------------------------------------------------------
// ctes_secs: seconds scaling and output stages
// Scales the day count to seconds, adds the time of day, then removes the
// extra day counted for the day of month, clamping at zero.
// ----------------------------------------------------------------------------
module ctes_secs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  ctes_pkg::day_item_t         up_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ctes_pkg::OutW-1:0]   epoch_seconds
);

  logic                        c_valid;
  logic [ctes_pkg::OutW-1:0]   c_total;
  logic                        d_valid;
  logic [ctes_pkg::OutW-1:0]   d_secs;

  logic                        c_adv;
  logic                        d_adv;
  logic [ctes_pkg::OutW-1:0]   total_next;
  logic [ctes_pkg::OutW-1:0]   secs_next;

  assign d_adv    = !d_valid || !out_stall;
  assign c_adv    = !c_valid || d_adv;
  assign up_ready = c_adv;

  always_comb begin
    total_next = 33'(up_item.days) * 33'(ctes_pkg::SecsPerDay) + 33'(up_item.tod_secs);
    // Day zero of January in 1970 or before can go negative; clamp it.
    if (c_total >= 33'(ctes_pkg::SecsPerDay)) begin
      secs_next = c_total - 33'(ctes_pkg::SecsPerDay);
    end else begin
      secs_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (c_adv) begin
        c_valid <= up_valid;
      end
      if (d_adv) begin
        d_valid <= c_valid;
      end
    end
    if (c_adv && up_valid) begin
      c_total <= total_next;
    end
    if (d_adv && c_valid) begin
      d_secs <= secs_next;
    end
  end

  assign out_valid     = d_valid;
  assign epoch_seconds = d_secs;

  a_reset_clear: assert property (@(posedge clk) rst |=> !c_valid && !d_valid)
    else $error("seconds stages hold a transaction after reset");

  a_move_lands: assert property (@(posedge clk) disable iff (rst)
    (c_valid && d_adv) |=> d_valid)
    else $error("transaction lost between stage C and output");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !d_adv) |=> c_valid && $stable(c_total))
    else $error("stage C changed while the output was stalled");

endmodule

@@ dv/epoch_seconds_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_checker: result predictor and scoreboard for the epoch unit
// Watches both channels of the civil time converter, works out the expected
// epoch seconds for every accepted input transaction and compares each
// accepted output transaction with the oldest expected value.
// ----------------------------------------------------------------------------
module epoch_seconds_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ctes_pkg::YearW-1:0]  years_since_1900,
  input  logic [ctes_pkg::MonW-1:0]   month_index,
  input  logic [ctes_pkg::MdayW-1:0]  day_of_month,
  input  logic [ctes_pkg::HourW-1:0]  hour_of_day,
  input  logic [ctes_pkg::MinW-1:0]   minute_of_hour,
  input  logic [ctes_pkg::SecW-1:0]   second_of_minute,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ctes_pkg::OutW-1:0]   epoch_seconds,
  output int                          fail_count,
  output int                          outstanding
);

  localparam int unsigned EpochYear     = 1970;
  localparam int unsigned YearBase      = 1900;
  localparam int unsigned FebMonth      = 1;
  localparam int unsigned MonthsPerYear = 12;
  localparam longint      SecondsMax    = (longint'(1) << ctes_pkg::OutW) - 1;

  logic [ctes_pkg::OutW-1:0] expected_seconds[$];
  int unsigned               result_index;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    result_index = 0;
  end

  function automatic bit is_leap_year(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned month);
    case (month)
      FebMonth:        return 28;
      3, 5, 8, 10:     return 30;
      default:         return 31;
    endcase
  endfunction

  // Whole years since 1970, whole months of this year, then day and time of day.
  function automatic logic [ctes_pkg::OutW-1:0] civil_to_epoch(
    input logic [ctes_pkg::YearW-1:0] year_off,
    input logic [ctes_pkg::MonW-1:0]  month,
    input logic [ctes_pkg::MdayW-1:0] mday,
    input logic [ctes_pkg::HourW-1:0] hour,
    input logic [ctes_pkg::MinW-1:0]  minute,
    input logic [ctes_pkg::SecW-1:0]  second
  );
    int unsigned year;
    int unsigned yr;
    int unsigned mon;
    int unsigned month_count;
    bit          leap;
    longint      days;
    longint      total;
    year = int'(year_off) + YearBase;
    leap = is_leap_year(year);
    days = 0;
    for (yr = EpochYear; yr < year; yr++)
      days += is_leap_year(yr) ? 366 : 365;
    month_count = (month < MonthsPerYear) ? month : MonthsPerYear;
    for (mon = 0; mon < month_count; mon++) begin
      days += days_in_month(mon);
      if (mon == FebMonth && leap)
        days += 1;
    end
    days += longint'(mday) - 1;
    total = days * ctes_pkg::SecsPerDay + longint'(hour) * ctes_pkg::SecsPerHour
          + longint'(minute) * ctes_pkg::SecsPerMin + longint'(second);
    if (total < 0)
      return '0;
    else if (total > SecondsMax)
      return '1;
    else
      return total[ctes_pkg::OutW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [ctes_pkg::OutW-1:0] got,
                                 input logic [ctes_pkg::OutW-1:0] want);
    $display("[%0t] result %0d: %s: got %0d, expected %0d", $time, result_index, what,
             got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_seconds.push_back(civil_to_epoch(years_since_1900, month_index,
                                                  day_of_month, hour_of_day,
                                                  minute_of_hour, second_of_minute));
      if (out_valid && !out_stall) begin
        if (expected_seconds.size() == 0)
          report_mismatch("unexpected transaction", epoch_seconds, '0);
        else if (epoch_seconds !== expected_seconds[0])
          report_mismatch("epoch_seconds", epoch_seconds, expected_seconds[0]);
        if (expected_seconds.size() != 0)
          void'(expected_seconds.pop_front());
        result_index++;
      end
      outstanding <= expected_seconds.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for civil_time_to_epoch_seconds_unit
// Drives civil time transactions into the converter in random bursts while
// the output side stalls on a changing pattern. A separate checker predicts
// and compares every result; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb;

  // The run is bounded by this many clock cycles. The slowest correct run,
  // with the longest sender gaps and heavy output stalls on every transaction,
  // stays well inside this bound.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 1150;
  // The pipeline is four stages deep; after the last result we linger a bit
  // longer so that any stray extra output transaction is still caught.
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned ResetCycles  = 11;

  // Output stall patterns. Each one holds for a random stretch of cycles,
  // so that stalls land on every phase of the pipeline and there are also
  // long stretches where the output never stalls at all.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_e;

  logic clk;
  logic rst = 1'b1;

  logic                        in_valid         = 1'b0;
  logic                        in_stall;
  logic [ctes_pkg::YearW-1:0]  years_since_1900 = '0;
  logic [ctes_pkg::MonW-1:0]   month_index      = '0;
  logic [ctes_pkg::MdayW-1:0]  day_of_month     = '0;
  logic [ctes_pkg::HourW-1:0]  hour_of_day      = '0;
  logic [ctes_pkg::MinW-1:0]   minute_of_hour   = '0;
  logic [ctes_pkg::SecW-1:0]   second_of_minute = '0;
  logic                        out_valid;
  logic                        out_stall        = 1'b0;
  logic [ctes_pkg::OutW-1:0]   epoch_seconds;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;

  stall_mode_e stall_mode      = STALL_NONE;
  int unsigned stall_mode_left = 0;
  int unsigned stall_phase     = 0;

  // Transactions left in the current sender burst before the next gap.
  int unsigned burst_left = 0;

  civil_time_to_epoch_seconds_unit uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .epoch_seconds    (epoch_seconds)
  );

  epoch_seconds_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .epoch_seconds    (epoch_seconds),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output stall generator. Exactly one nonblocking write per clock edge.
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    stall_phase = (stall_phase == 2) ? 0 : stall_phase + 1;
    case (stall_mode)
      STALL_NONE:        out_stall <= 1'b0;
      STALL_LIGHT:       out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:       out_stall <= ($urandom_range(0, 9) < 6);
      STALL_EVERY_THIRD: out_stall <= (stall_phase == 0);
      default:           out_stall <= 1'b0;
    endcase
  end

  // Watchdog: if the run has not finished within the limit, something hung.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("civil_time_to_epoch_seconds_unit: mismatch");
    $finish;
  end

  // Picks the length of the next burst. Mostly short bursts, but now and then
  // a long one so that the input side also runs for a while with no gaps.
  function automatic int unsigned pick_burst_length();
    if ($urandom_range(0, 4) == 0)
      return $urandom_range(40, 120);
    return $urandom_range(0, 15);
  endfunction

  // Presents one transaction and holds it until the unit takes it. The valid
  // stays high across a burst; only at the end of a burst is it lowered, and
  // then a gap follows, so that valid never gets two writes in one
  // time step. The stall seen right after the edge is the value that edge used.
  task automatic send_conversion(
    input logic [ctes_pkg::YearW-1:0] year_off,
    input logic [ctes_pkg::MonW-1:0]  month,
    input logic [ctes_pkg::MdayW-1:0] mday,
    input logic [ctes_pkg::HourW-1:0] hour,
    input logic [ctes_pkg::MinW-1:0]  minute,
    input logic [ctes_pkg::SecW-1:0]  second
  );
    in_valid         <= 1'b1;
    years_since_1900 <= year_off;
    month_index      <= month;
    day_of_month     <= mday;
    hour_of_day      <= hour;
    minute_of_hour   <= minute;
    second_of_minute <= second;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = pick_burst_length();
    end else begin
      burst_left--;
    end
  endtask

  // Random transaction. Most fields stay inside their calendar range, but a
  // good share uses the full bit width so that every input bit toggles and
  // the out-of-range hour, minute, second and month codes get exercised.
  // A day of zero is mixed in as well, since it steps back into the prior month.
  task automatic send_random_conversion();
    logic [ctes_pkg::MonW-1:0]  month;
    logic [ctes_pkg::MdayW-1:0] mday;
    logic [ctes_pkg::HourW-1:0] hour;
    logic [ctes_pkg::MinW-1:0]  minute;
    logic [ctes_pkg::SecW-1:0]  second;
    int unsigned                pick;
    month  = 4'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 11)
                                             : $urandom_range(0, 15));
    pick   = $urandom_range(0, 19);
    mday   = 5'((pick == 0) ? 0 : (pick < 3) ? $urandom_range(0, 31)
                                              : $urandom_range(1, 31));
    hour   = 5'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 23)
                                             : $urandom_range(0, 31));
    minute = 6'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 59)
                                             : $urandom_range(0, 63));
    second = 6'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 60)
                                             : $urandom_range(0, 63));
    send_conversion(8'($urandom_range(0, 255)), month, mday, hour, minute, second);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    burst_left = pick_burst_length();

    // Directed transactions: the epoch itself, day zero right at the epoch
    // (the total goes negative and must clamp to zero), years before 1970,
    // leap and non-leap centuries, month codes past December, the leap
    // second, and fields at their full-width maximum.
    send_conversion(70,  0,  1,  0,  0,  0);
    send_conversion(70,  0,  0,  0,  0,  0);
    send_conversion(70,  0,  0, 23, 59, 59);
    send_conversion(70,  0,  0, 31, 63, 63);
    send_conversion(0,   0,  1,  0,  0,  0);
    send_conversion(69,  1, 28, 12,  0,  0);
    send_conversion(68,  2,  1,  0,  0,  0);
    send_conversion(10,  5,  0,  0,  0,  0);
    send_conversion(0,  15,  0,  0,  0,  0);
    send_conversion(72,  1, 29, 12, 30, 30);
    send_conversion(71, 12,  0,  0,  0,  0);
    send_conversion(70, 15,  1,  0,  0,  0);
    send_conversion(70, 11, 31, 23, 59, 60);
    send_conversion(100, 2,  1,  0,  0,  0);
    send_conversion(200, 2,  1,  0,  0,  0);
    send_conversion(204, 2,  1,  0,  0,  0);
    send_conversion(130, 1, 29,  6, 15, 45);
    send_conversion(150, 7, 16, 10, 45, 60);
    send_conversion(199, 12, 1,  0,  0,  0);
    send_conversion(255, 0,  0,  0,  0,  0);
    send_conversion(255, 11, 31, 23, 59, 60);
    send_conversion(255, 15, 31, 31, 63, 63);

    repeat (RandomItems)
      send_random_conversion();

    // Drop valid once the last transaction is in, unless a gap already did.
    if (in_valid)
      in_valid <= 1'b0;

    // The checker updates its count at each edge, so the count is only
    // looked at once an edge has passed since the last transaction went in.
    do begin
      @(posedge clk);
    end while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("civil_time_to_epoch_seconds_unit: match");
    else
      $display("civil_time_to_epoch_seconds_unit: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ctes_pkg.sv
hw/rtl/ctes_days.sv
hw/rtl/ctes_secs.sv
hw/rtl/civil_time_to_epoch_seconds_unit.sv
dv/epoch_seconds_checker.sv
dv/tb.sv
